// File: hdl/kf_pkg.sv
// Shared types, widths, register indexes and helpers for the scalar Kalman filter.
`timescale 1ns / 1ps

package kf_pkg;

    localparam int DATA_W    = 32;
    localparam int NOISE_W   = 31;
    localparam int GAIN_W    = 17;
    localparam int GAIN_FRAC = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_SUM,
        ST_DSTART,
        ST_DIV,
        ST_MSTART,
        ST_MUL,
        ST_UPD
    } state_t;

    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
    endfunction

endpackage

// File: hdl/kf_if.sv
// Valid/ready channel interfaces: observation samples, results and register writes.
`timescale 1ns / 1ps

interface kf_sample_if;
    logic                             valid;
    logic                             ready;
    logic signed [kf_pkg::DATA_W-1:0] observation;

    modport source (output valid, output observation, input ready);
    modport sink   (input valid, input observation, output ready);
endinterface

interface kf_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [kf_pkg::DATA_W-1:0] estimate;
    logic        [kf_pkg::GAIN_W-1:0] gain;

    modport source (output valid, output estimate, output gain, input ready);
    modport sink   (input valid, input estimate, input gain, output ready);
endinterface

interface kf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kf_pkg::CFG_IDX_W-1:0]   index;
    logic [kf_pkg::NOISE_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/kf_div.sv
// Bit-serial restoring divider: quotient floor(num * 2^F / den) for num <= den.
`timescale 1ns / 1ps

module kf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [kf_pkg::DATA_W-1:0]    num,
    input  logic [kf_pkg::DATA_W-1:0]    den,
    output logic                         done,
    output logic [FRAC_BITS:0]           quot
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int DW    = kf_pkg::DATA_W;

    logic [DW:0]        rem_reg, rem_next;
    logic [FRAC_BITS:0] quot_reg, quot_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DW+1:0]      trial;
    logic               ge;

    always_comb
    begin
        trial     = {1'b0, rem_reg} - {2'b00, den};
        ge        = !trial[DW+1];
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, num};
            quot_next = '0;
            cnt_next  = CW'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[FRAC_BITS-1:0], ge};
            rem_next  = {(ge ? trial[DW-1:0] : rem_reg[DW-1:0]), 1'b0};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: hdl/kf_mul.sv
// Bit-serial shift-add multipliers: estimate correction K*diff/2^F and covariance (1-K)*P'/2^F.
`timescale 1ns / 1ps

module kf_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [FRAC_BITS:0]               k,
    input  logic signed [kf_pkg::DATA_W:0]   diff,
    input  logic [kf_pkg::DATA_W-1:0]        p_pred,
    output logic                             done,
    output logic signed [kf_pkg::DATA_W+1:0] corr,
    output logic [kf_pkg::DATA_W-1:0]        cov
);

    localparam int KW    = FRAC_BITS + 1;
    localparam int STEPS = KW;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int DW    = kf_pkg::DATA_W;
    localparam logic [KW-1:0] ONE_K = KW'(1) << FRAC_BITS;

    logic [KW-1:0]        kd_reg, kd_next;
    logic [KW-1:0]        kc_reg, kc_next;
    logic signed [DW+2:0] hid_reg, hid_next;
    logic [KW-1:0]        lod_reg, lod_next;
    logic [DW:0]          hic_reg, hic_next;
    logic [KW-1:0]        loc_reg, loc_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic signed [DW+2:0] sum_d;
    logic [DW+1:0]        sum_c;

    always_comb
    begin
        sum_d     = hid_reg + (kd_reg[0] ? (DW+3)'(diff) : '0);
        sum_c     = {1'b0, hic_reg} + (kc_reg[0] ? {2'b00, p_pred} : '0);
        kd_next   = kd_reg;
        kc_next   = kc_reg;
        hid_next  = hid_reg;
        lod_next  = lod_reg;
        hic_next  = hic_reg;
        loc_next  = loc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            kd_next   = k;
            kc_next   = ONE_K - k;
            hid_next  = '0;
            lod_next  = '0;
            hic_next  = '0;
            loc_next  = '0;
            cnt_next  = CW'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            kd_next  = kd_reg >> 1;
            kc_next  = kc_reg >> 1;
            hid_next = sum_d >>> 1;
            lod_next = {sum_d[0], lod_reg[KW-1:1]};
            hic_next = sum_c[DW+1:1];
            loc_next = {sum_c[0], loc_reg[KW-1:1]};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kd_reg  <= kd_next;
        kc_reg  <= kc_next;
        hid_reg <= hid_next;
        lod_reg <= lod_next;
        hic_reg <= hic_next;
        loc_reg <= loc_next;
    end

    // floor shift by F: drop the low F product bits
    assign corr = {hid_reg[DW:0], lod_reg[KW-1]};
    assign cov  = {hic_reg[DW-2:0], loc_reg[KW-1]};
    assign done = done_reg;

endmodule

// File: hdl/scalar_kalman_filter.sv
// Scalar Kalman filter top level: sequencer, state registers, config registers, result register.
// Sequence per sample: predict, sum, divide for the gain, multiply for the update, result register.
// Sample rate is set by the serial divider and the serial multipliers; a result stalled at the
// output also holds off the next sample; one sample in flight at a time.
// Reset: asynchronous active low; clears estimate and covariance, loads Q=0.1 and R=1.
`timescale 1ns / 1ps

module scalar_kalman_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    kf_cfg_if.sink        cfg,
    kf_sample_if.sink     sample,
    kf_result_if.source   result
);

    localparam int    DW     = kf_pkg::DATA_W;
    localparam int    NW     = kf_pkg::NOISE_W;
    localparam int    GW     = kf_pkg::GAIN_W;
    localparam int    KW     = FRAC_BITS + 1;
    localparam int    GSHR   = (FRAC_BITS > kf_pkg::GAIN_FRAC) ? FRAC_BITS - kf_pkg::GAIN_FRAC : 0;
    localparam int    GSHL   = (FRAC_BITS < kf_pkg::GAIN_FRAC) ? kf_pkg::GAIN_FRAC - FRAC_BITS : 0;
    localparam longint ONE_FX = 64'sd1 << FRAC_BITS;
    localparam logic [NW-1:0] Q_RST = NW'((ONE_FX + 5) / 10);
    localparam logic [NW-1:0] R_RST = NW'(ONE_FX);
    localparam logic signed [DW+2:0] EST_MAX = (DW+3)'(64'sh7FFF_FFFF);
    localparam logic signed [DW+2:0] EST_MIN = -(DW+3)'(64'sh8000_0000);

    kf_pkg::state_t state_reg, state_next;

    logic [NW-1:0]        q_reg, r_reg;
    logic signed [DW-1:0] est_reg, est_next;
    logic [DW-1:0]        cov_reg, cov_next;
    logic signed [DW-1:0] obs_reg, obs_next;
    logic [DW-1:0]        pp_reg, pp_next;
    logic [DW-1:0]        s_reg, s_next;
    logic signed [DW:0]   diff_reg, diff_next;
    logic [KW-1:0]        k_reg, k_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [DW-1:0] out_est_reg, out_est_next;
    logic [GW-1:0]        out_gain_reg, out_gain_next;

    logic                 div_start, div_done;
    logic                 mul_start, mul_done;
    logic [KW-1:0]        div_quot;
    logic signed [DW+1:0] mul_corr;
    logic [DW-1:0]        mul_cov;
    logic signed [DW+2:0] x_sum;
    logic [KW+GSHL-1:0]   k_ext;

    kf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (pp_reg),
        .den   (s_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    kf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .k      (k_reg),
        .diff   (diff_reg),
        .p_pred (pp_reg),
        .done   (mul_done),
        .corr   (mul_corr),
        .cov    (mul_cov)
    );

    always_comb
    begin
        state_next     = state_reg;
        est_next       = est_reg;
        cov_next       = cov_reg;
        obs_next       = obs_reg;
        pp_next        = pp_reg;
        s_next         = s_reg;
        diff_next      = diff_reg;
        k_next         = k_reg;
        out_est_next   = out_est_reg;
        out_gain_next  = out_gain_reg;
        out_valid_next = out_valid_reg && !result.ready;
        div_start      = 1'b0;
        mul_start      = 1'b0;
        sample.ready   = 1'b0;
        x_sum          = (DW+3)'(est_reg) + (DW+3)'(mul_corr);
        k_ext          = (KW+GSHL)'(k_reg) << GSHL;

        unique case (state_reg)
            kf_pkg::ST_IDLE:
            begin
                sample.ready = 1'b1;
                if (sample.valid)
                begin
                    obs_next   = sample.observation;
                    state_next = kf_pkg::ST_PRED;
                end
            end
            kf_pkg::ST_PRED:
            begin
                pp_next    = kf_pkg::sat_add(cov_reg, {1'b0, q_reg});
                diff_next  = (DW+1)'(obs_reg) - (DW+1)'(est_reg);
                state_next = kf_pkg::ST_SUM;
            end
            kf_pkg::ST_SUM:
            begin
                s_next     = kf_pkg::sat_add(pp_reg, {1'b0, r_reg});
                state_next = kf_pkg::ST_DSTART;
            end
            kf_pkg::ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = kf_pkg::ST_DIV;
            end
            kf_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    k_next     = (s_reg == '0) ? '0 : div_quot;
                    state_next = kf_pkg::ST_MSTART;
                end
            end
            kf_pkg::ST_MSTART:
            begin
                mul_start  = 1'b1;
                state_next = kf_pkg::ST_MUL;
            end
            kf_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = kf_pkg::ST_UPD;
                end
            end
            kf_pkg::ST_UPD:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    priority if (x_sum > EST_MAX)
                        est_next = DW'(EST_MAX);
                    else if (x_sum < EST_MIN)
                        est_next = DW'(EST_MIN);
                    else
                        est_next = DW'(x_sum);
                    cov_next       = mul_cov;
                    out_est_next   = est_next;
                    out_gain_next  = GW'(k_ext >> GSHR);
                    out_valid_next = 1'b1;
                    state_next     = kf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            est_reg       <= '0;
            cov_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            est_reg       <= est_next;
            cov_reg       <= cov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obs_reg      <= obs_next;
        pp_reg       <= pp_next;
        s_reg        <= s_next;
        diff_reg     <= diff_next;
        k_reg        <= k_next;
        out_est_reg  <= out_est_next;
        out_gain_reg <= out_gain_next;
    end

    // register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= Q_RST;
            r_reg <= R_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == kf_pkg::CFG_PROCESS_NOISE)
                q_reg <= cfg.data;
            if (cfg.index == kf_pkg::CFG_MEASUREMENT_NOISE)
                r_reg <= cfg.data;
        end
    end

    assign cfg.ready       = 1'b1;
    assign result.valid    = out_valid_reg;
    assign result.estimate = out_est_reg;
    assign result.gain     = out_gain_reg;

endmodule

// File: hdl/kf_checker.sv
// Port-level assertions for the scalar Kalman filter, bound to the top level.
`timescale 1ns / 1ps

module kf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             sample_valid,
    input logic                             sample_ready,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic signed [kf_pkg::DATA_W-1:0] result_estimate,
    input logic [kf_pkg::GAIN_W-1:0]        result_gain
);

    localparam logic [kf_pkg::GAIN_W-1:0] GAIN_ONE = kf_pkg::GAIN_W'(1) << kf_pkg::GAIN_FRAC;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample taken while another is in flight");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !$rose(result_valid))
        else $error("result appeared right after a sample transfer");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_gain <= GAIN_ONE)
        else $error("gain above one");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_estimate) && $stable(result_gain))
        else $error("stalled result changed");

endmodule

bind scalar_kalman_filter kf_checker u_kf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .sample_valid    (sample.valid),
    .sample_ready    (sample.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_estimate (result.estimate),
    .result_gain     (result.gain)
);

// File: bench/scalar_kalman_filter_tb.sv
// Self-checking testbench for the scalar Kalman filter: directed table, random phases, stalls.
`timescale 1ns / 1ps

module scalar_kalman_filter_tb;

    localparam int FRAC_BITS = 16;
    localparam int LATENCY   = 2 * FRAC_BITS + 9;
    localparam int WATCHDOG  = 4000;
    localparam int HOLD_AT   = 40;
    localparam int HOLD_LEN  = 400;
    localparam int PHASE_LEN = 100;
    localparam int PHASES    = 5;
    localparam int PLAN_LEN  = 23;

    localparam int DATA_W    = kf_pkg::DATA_W;
    localparam int NOISE_W   = kf_pkg::NOISE_W;
    localparam int GAIN_W    = kf_pkg::GAIN_W;
    localparam int CFG_IDX_W = kf_pkg::CFG_IDX_W;

    localparam logic [NOISE_W-1:0] Q_AT_RESET = NOISE_W'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [NOISE_W-1:0] R_AT_RESET = NOISE_W'(1 << FRAC_BITS);
    localparam logic [NOISE_W-1:0] NOISE_MAX  = '1;
    localparam longint EST_MAX = 64'sd2147483647;
    localparam longint EST_MIN = -64'sd2147483648;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] estimate;
        logic        [GAIN_W-1:0] gain;
    } kf_result_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     index;
        logic [NOISE_W-1:0]       value;
        logic signed [DATA_W-1:0] obs;
        logic                     typed;
        logic signed [DATA_W-1:0] est;
        logic [GAIN_W-1:0]        gain;
    } plan_row_t;

    // directed sequence; typed rows carry the result expected by hand
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_SAMPLE, '0, '0, 32'sh0000_0000, 1'b1, 32'sh0000_0000, 17'd5958},
        '{ROW_SAMPLE, '0, '0, 32'sh7FFF_FFFF, 1'b0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh8000_0000, 1'b0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh0001_0000, 1'b0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 32'shFFFF_FFFF, 1'b0, '0, '0},
        '{ROW_WRITE, kf_pkg::CFG_MEASUREMENT_NOISE, 31'd0, '0, 1'b0, '0, '0},
        '{ROW_WRITE, kf_pkg::CFG_PROCESS_NOISE, 31'd1, '0, 1'b0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 17'd65536},
        '{ROW_WRITE, kf_pkg::CFG_PROCESS_NOISE, 31'd0, '0, 1'b0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh8000_0000, 1'b1, 32'sh7FFF_FFFF, 17'd0},
        '{ROW_SAMPLE, '0, '0, 32'sh0000_0000, 1'b1, 32'sh7FFF_FFFF, 17'd0},
        '{ROW_WRITE, kf_pkg::CFG_PROCESS_NOISE, 31'h7FFF_FFFF, '0, 1'b0, '0, '0},
        '{ROW_WRITE, kf_pkg::CFG_MEASUREMENT_NOISE, 31'h7FFF_FFFF, '0, 1'b0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh8000_0000, 1'b0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh7FFF_FFFF, 1'b0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh8000_0000, 1'b0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh0000_0000, 1'b0, '0, '0},
        '{ROW_WRITE, CFG_SPARE_A, 31'd5, '0, 1'b0, '0, '0},
        '{ROW_WRITE, CFG_SPARE_B, 31'h7FFF_FFFF, '0, 1'b0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh1234_5678, 1'b0, '0, '0},
        '{ROW_WRITE, kf_pkg::CFG_PROCESS_NOISE, 31'd6554, '0, 1'b0, '0, '0},
        '{ROW_WRITE, kf_pkg::CFG_MEASUREMENT_NOISE, 31'd65536, '0, 1'b0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 32'shFFFF_0000, 1'b0, '0, '0}
    };

    logic clk;
    logic rst_n;

    kf_cfg_if    cfg_ch();
    kf_sample_if sample_ch();
    kf_result_if result_ch();

    scalar_kalman_filter #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (sample_ch),
        .result (result_ch)
    );

    logic signed [DATA_W-1:0] est_model;
    logic        [DATA_W-1:0] cov_model;
    logic        [NOISE_W-1:0] q_model;
    logic        [NOISE_W-1:0] r_model;

    kf_result_t expected_q [$];
    kf_result_t want;
    int errors;
    int results_seen;
    int idle_cycles;
    int burst_left;
    logic hold_req;

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one filter update: advances the model state and returns the expected output
    function automatic kf_result_t kalman_update(input logic signed [DATA_W-1:0] obs);
        logic [DATA_W:0]     sum;
        logic [DATA_W-1:0]   p_pred;
        logic [DATA_W-1:0]   s_tot;
        logic [63:0]         k;
        logic signed [63:0]  diff;
        logic signed [63:0]  prod;
        logic signed [63:0]  x;
        logic [63:0]         cov_next;
        kf_result_t          res;
        sum    = {1'b0, cov_model} + {2'b0, q_model};
        p_pred = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
        sum    = {1'b0, p_pred} + {2'b0, r_model};
        s_tot  = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
        if (s_tot == 0)
            k = 64'd0;
        else
            k = ({32'b0, p_pred} << FRAC_BITS) / {32'b0, s_tot};
        if (k > (64'd1 << FRAC_BITS))
            k = 64'd1 << FRAC_BITS;
        diff = obs - est_model;
        prod = $signed(k) * diff;
        x    = est_model + (prod >>> FRAC_BITS);
        if (x > EST_MAX)
            x = EST_MAX;
        if (x < EST_MIN)
            x = EST_MIN;
        est_model    = x[DATA_W-1:0];
        cov_next     = (((64'd1 << FRAC_BITS) - k) * {32'b0, p_pred}) >> FRAC_BITS;
        cov_model    = cov_next[DATA_W-1:0];
        res.estimate = est_model;
        res.gain     = GAIN_W'(k >> (FRAC_BITS - kf_pkg::GAIN_FRAC));
        return res;
    endfunction

    task automatic send_sample(input logic signed [DATA_W-1:0] obs, input logic typed,
                               input kf_result_t typed_res);
        kf_result_t model_res;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 60)) @(negedge clk);
            end
        end
        burst_left--;
        sample_ch.valid       <= 1'b1;
        sample_ch.observation <= obs;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        model_res = kalman_update(obs);
        expected_q.push_back(typed ? typed_res : model_res);
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic settle();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [NOISE_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        case (index)
            kf_pkg::CFG_PROCESS_NOISE:     q_model = value;
            kf_pkg::CFG_MEASUREMENT_NOISE: r_model = value;
            default: ;
        endcase
    endtask

    // result side: stall pattern plus one long hold-off
    initial
    begin
        int stall_cnt;
        int hold_left;
        logic hold_taken;
        stall_cnt  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall_cnt++;
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case ((stall_cnt / 700) % 3)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: result_ch.ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            results_seen++;
            if (results_seen == HOLD_AT)
                hold_req <= 1'b1;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: estimate %0d gain %0d", $time,
                         result_ch.estimate, result_ch.gain);
            end
            else
            begin
                want = expected_q.pop_front();
                if (result_ch.estimate !== want.estimate)
                begin
                    errors++;
                    $display("%0t: estimate mismatch: expected %0d, actual %0d", $time,
                             want.estimate, result_ch.estimate);
                end
                if (result_ch.gain !== want.gain)
                begin
                    errors++;
                    $display("%0t: gain mismatch: expected %0d, actual %0d", $time,
                             want.gain, result_ch.gain);
                end
            end
        end
        if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int i;
        int n;
        int phase;
        int level;
        logic signed [DATA_W-1:0] obs;
        kf_result_t none;
        none         = '0;
        errors       = 0;
        results_seen = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        hold_req     = 1'b0;
        est_model    = '0;
        cov_model    = '0;
        q_model      = Q_AT_RESET;
        r_model      = R_AT_RESET;
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.observation = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = kf_pkg::CFG_PROCESS_NOISE;
        cfg_ch.data           = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].index, plan[i].value);
            else
                send_sample(plan[i].obs, plan[i].typed, '{plan[i].est, plan[i].gain});
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(kf_pkg::CFG_PROCESS_NOISE, NOISE_W'($urandom_range(0, 1 << 20)));
                    write_reg(kf_pkg::CFG_MEASUREMENT_NOISE,
                              NOISE_W'($urandom_range(0, 1 << 20)));
                end
                1:
                begin
                    write_reg(kf_pkg::CFG_PROCESS_NOISE, '0);
                    write_reg(kf_pkg::CFG_MEASUREMENT_NOISE, NOISE_W'($urandom));
                end
                2:
                begin
                    write_reg(kf_pkg::CFG_PROCESS_NOISE, NOISE_MAX);
                    write_reg(kf_pkg::CFG_MEASUREMENT_NOISE, NOISE_W'($urandom_range(0, 255)));
                end
                3:
                begin
                    write_reg(kf_pkg::CFG_PROCESS_NOISE, NOISE_W'($urandom));
                    write_reg(kf_pkg::CFG_MEASUREMENT_NOISE, NOISE_MAX);
                end
                default:
                begin
                    write_reg(kf_pkg::CFG_PROCESS_NOISE, NOISE_W'($urandom_range(0, 1 << 16)));
                    write_reg(kf_pkg::CFG_MEASUREMENT_NOISE, '0);
                end
            endcase
            level = $urandom;
            for (n = 0; n < PHASE_LEN; n++)
            begin
                case ($urandom_range(0, 9))
                    0:
                        case ($urandom_range(0, 3))
                            0:       obs = 32'sh7FFF_FFFF;
                            1:       obs = 32'sh8000_0000;
                            2:       obs = 32'sh0000_0000;
                            default: obs = 32'shFFFF_FFFF;
                        endcase
                    1, 2:
                        obs = $urandom;
                    default:
                        obs = level + int'($urandom_range(0, 1 << 18)) - (1 << 17);
                endcase
                send_sample(obs, 1'b0, none);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
hdl/kf_pkg.sv
hdl/kf_if.sv
hdl/kf_div.sv
hdl/kf_mul.sv
hdl/scalar_kalman_filter.sv
hdl/kf_checker.sv
bench/scalar_kalman_filter_tb.sv
